### hw/rtl/mapsum_pkg.sv
// Shared types, constants and the strip masking function for the adjacent pair sum block.
`timescale 1ns / 1ps

package mapsum_pkg;

    localparam int WORD_BITS      = 20;
    localparam int VALUE_BITS_CAP = 18;
    localparam int SUM_BITS       = VALUE_BITS_CAP + 1;
    localparam int FIELD_COUNT    = 5;
    localparam int COUNT_BITS     = 3;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 5;
    localparam int DEF_MAX_STRIPS = 5;

    localparam logic [COUNT_BITS-1:0]    RST_ACTIVE_STRIPS = 3'd5;
    localparam logic [CFG_DATA_BITS-1:0] RST_VALUE_BITS    = 5'd12;
    localparam logic [CFG_DATA_BITS-1:0] RST_FLAG_POSITION = 5'd13;

    typedef logic [WORD_BITS-1:0]      t_word;
    typedef logic [VALUE_BITS_CAP-1:0] t_value;
    typedef logic [SUM_BITS-1:0]       t_sum;
    typedef logic [COUNT_BITS-1:0]     t_count;
    typedef logic [CFG_DATA_BITS-1:0]  t_cfg_field;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ACTIVE_STRIPS = 2'd0,
        CFG_VALUE_BITS    = 2'd1,
        CFG_FLAG_POSITION = 2'd2
    } t_cfg_idx;

    // Control that travels with one beat through the pipeline.
    typedef struct packed {
        logic   valid;
        t_count count;
    } t_ctrl;

    // A strip is zero when its flag is set; otherwise its low width bits are kept.
    // The width is already clamped to VALUE_BITS_CAP by the caller.
    function automatic t_value strip_value(t_word word, t_cfg_field width,
                                           t_cfg_field flag_at);
        t_value mask;
        logic   flagged;
        mask    = ~({VALUE_BITS_CAP{1'b1}} << width);
        flagged = (flag_at < t_cfg_field'(WORD_BITS)) && word[flag_at];
        return flagged ? '0 : (word[VALUE_BITS_CAP-1:0] & mask);
    endfunction

endpackage

### hw/rtl/mapsum_lane.sv
// One lane: masks two neighboring strips and registers their sum.
`timescale 1ns / 1ps

module mapsum_lane (
    input  logic                 i_clk,
    input  mapsum_pkg::t_word    i_word_lo,
    input  mapsum_pkg::t_word    i_word_hi,
    input  mapsum_pkg::t_cfg_field i_width,
    input  mapsum_pkg::t_cfg_field i_flag_at,
    output mapsum_pkg::t_sum     o_sum
);
    import mapsum_pkg::*;

    t_sum r_sum;
    t_sum n_sum;

    always_comb begin
        n_sum = {1'b0, strip_value(i_word_lo, i_width, i_flag_at)}
              + {1'b0, strip_value(i_word_hi, i_width, i_flag_at)};
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

### hw/rtl/mapsum_merge.sv
// Merging stage: picks the largest active pair sum, or strip zero alone.
`timescale 1ns / 1ps

module mapsum_merge #(
    parameter int NUM_PAIRS = mapsum_pkg::DEF_MAX_STRIPS - 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mapsum_pkg::t_ctrl  i_ctrl,
    input  mapsum_pkg::t_sum   i_sums [NUM_PAIRS],
    input  mapsum_pkg::t_value i_single,
    output logic               o_valid,
    output mapsum_pkg::t_sum   o_best
);
    import mapsum_pkg::*;

    logic r_valid;
    t_sum r_best;
    t_sum n_best;

    // Pair k takes part when both of its strips are active, that is k + 2 <= count.
    always_comb begin
        n_best = '0;
        if (i_ctrl.count == t_count'(1)) begin
            n_best = {1'b0, i_single};
        end else begin
            for (int k = 0; k < NUM_PAIRS; k++) begin
                if ((COUNT_BITS+1)'(k + 2) <= {1'b0, i_ctrl.count} && i_sums[k] > n_best) begin
                    n_best = i_sums[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
    end

    assign o_valid = r_valid;
    assign o_best  = r_best;

endmodule

### hw/rtl/max_adjacent_pair_sum.sv
// Top level of the adjacent strip pair sum block.
`timescale 1ns / 1ps

// The block takes one sample time, the raw words of five neighboring strips, in every
// clock cycle in which start is high; busy is never raised, so back-to-back beats are
// always taken. Each beat gives exactly one result: o_valid is high for a single
// cycle and o_best_pair_sum holds the largest sum of two adjacent active strip
// values (or the first strip's value alone when only one strip is active). The
// receiver cannot stall the block, so it must capture the result in that cycle. The
// result passes two register stages: one lane per adjacent pair masks its two
// strips and registers their sum, and a merging stage registers the maximum over the
// lanes. Configuration registers may only be written while no beat is in flight.

module max_adjacent_pair_sum #(
    parameter int MAX_STRIPS = mapsum_pkg::DEF_MAX_STRIPS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  mapsum_pkg::t_word                    i_strip_zero,
    input  mapsum_pkg::t_word                    i_strip_one,
    input  mapsum_pkg::t_word                    i_strip_two,
    input  mapsum_pkg::t_word                    i_strip_three,
    input  mapsum_pkg::t_word                    i_strip_four,
    input  logic                                 i_cfg_we,
    input  logic [mapsum_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [mapsum_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                                 o_valid,
    output mapsum_pkg::t_sum                     o_best_pair_sum
);
    import mapsum_pkg::*;

    localparam int NUM_PAIRS = MAX_STRIPS - 1;

    // Configuration registers.
    t_count     r_active_strips;
    t_cfg_field r_value_bits;
    t_cfg_field r_flag_position;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_strips <= RST_ACTIVE_STRIPS;
            r_value_bits    <= RST_VALUE_BITS;
            r_flag_position <= RST_FLAG_POSITION;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ACTIVE_STRIPS: r_active_strips <= i_cfg_data[COUNT_BITS-1:0];
                CFG_VALUE_BITS:    r_value_bits    <= i_cfg_data;
                CFG_FLAG_POSITION: r_flag_position <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the strip count to one through MAX_STRIPS and the value width to its cap.
    t_count     active_count;
    t_cfg_field width;

    always_comb begin
        active_count = r_active_strips;
        if (active_count == '0) begin
            active_count = t_count'(1);
        end else if (active_count > t_count'(MAX_STRIPS)) begin
            active_count = t_count'(MAX_STRIPS);
        end
        width = (r_value_bits > t_cfg_field'(VALUE_BITS_CAP))
              ? t_cfg_field'(VALUE_BITS_CAP) : r_value_bits;
    end

    // The block never holds off a beat.
    assign busy = 1'b0;

    t_word words [FIELD_COUNT];
    assign words[0] = i_strip_zero;
    assign words[1] = i_strip_one;
    assign words[2] = i_strip_two;
    assign words[3] = i_strip_three;
    assign words[4] = i_strip_four;

    // First stage: control and the single-strip value travel beside the lane sums.
    t_ctrl  r_ctrl;
    t_value r_single;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl.valid <= start && !busy;
            r_ctrl.count <= active_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_single <= strip_value(words[0], width, r_flag_position);
    end

    t_sum lane_sums [NUM_PAIRS];

    for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_lane
        mapsum_lane u_lane (
            .i_clk     (i_clk),
            .i_word_lo (words[k]),
            .i_word_hi (words[k+1]),
            .i_width   (width),
            .i_flag_at (r_flag_position),
            .o_sum     (lane_sums[k])
        );
    end

    // Second stage: the merge registers the result and its strobe.
    mapsum_merge #(
        .NUM_PAIRS (NUM_PAIRS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (r_ctrl),
        .i_sums   (lane_sums),
        .i_single (r_single),
        .o_valid  (o_valid),
        .o_best   (o_best_pair_sum)
    );

endmodule
